// ===== rtl/core/integer_floor_square_root_unit_defines.svh =====
// Assertion macros for the integer floor square root unit.
// Plain SystemVerilog concurrent assertions; no other dependencies.
`ifndef INTEGER_FLOOR_SQUARE_ROOT_UNIT_DEFINES_SVH
`define INTEGER_FLOOR_SQUARE_ROOT_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define FSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// antecedent implies consequent after the delay given by dly
`define FSR_ASSERT_DELAY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fsr_pkg.sv =====
// Shared types and constants for the integer floor square root unit.
// No dependencies.
`timescale 1ns / 1ps

package fsr_pkg;

   localparam int DEF_INPUT_BITS  = 32;
   localparam int ROOT_FIELD_BITS = 16;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // per-step control broadcast to every cell of the row
   typedef struct packed {
      logic clear;   // load a new item: remainder to zero
      logic step;    // advance one root bit
      logic keep;    // trial fit: take the difference
   } cell_ctl_type;

endpackage

// ===== rtl/core/fsr_cell.sv =====
// One bit slice of the remainder row: holds a remainder bit and forms one
// bit of the trial subtraction. Depends on fsr_pkg.
`timescale 1ns / 1ps

module fsr_cell (
   input  logic                 clock,
   input  fsr_pkg::cell_ctl_type ctl,
   input  logic                 shift_in,   // remainder bit from two cells down (radicand bit in the lowest two)
   input  logic                 trial_in,
   input  logic                 borrow_in,
   output logic                 borrow_out,
   output logic                 rem_out
);
   import fsr_pkg::*;

   logic rem_ff;
   logic rem_in;
   logic diff;

   assign diff       = shift_in ^ trial_in ^ borrow_in;
   assign borrow_out = (~shift_in & trial_in) | (~(shift_in ^ trial_in) & borrow_in);

   always_comb begin
      rem_in = rem_ff;
      if (ctl.clear) begin
         rem_in = 1'b0;
      end else if (ctl.step) begin
         rem_in = ctl.keep ? diff : shift_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   assign rem_out = rem_ff;

endmodule

// ===== rtl/core/integer_floor_square_root_unit.sv =====
// Integer floor square root, ROOT_BITS = (INPUT_BITS + 1) / 2. A row of
// ROOT_BITS + 2 remainder cells settles one root bit per cycle through its
// borrow chain; busy is high while the row runs and start is ignored then.
// The result appears on rsp_root for exactly one cycle with rsp_valid and
// must be taken in that cycle. Depends on fsr_pkg, fsr_cell and the
// integer_floor_square_root_unit_defines.svh header.
`timescale 1ns / 1ps
`include "integer_floor_square_root_unit_defines.svh"

module integer_floor_square_root_unit #(
   parameter int INPUT_BITS = fsr_pkg::DEF_INPUT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [INPUT_BITS-1:0]                req_value,
   output logic                                 busy,
   output logic                                 rsp_valid,
   output logic [fsr_pkg::ROOT_FIELD_BITS-1:0]  rsp_root
);
   import fsr_pkg::*;

   localparam int ROOT_BITS = (INPUT_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int NCELLS    = ROOT_BITS + 2;
   localparam int CNT_BITS  = $clog2(ROOT_BITS + 1);
   localparam int LAT       = ROOT_BITS + 1;

   state_type                    state_ff, state_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [RAD_BITS-1:0]          rad_ff, rad_in;
   logic [ROOT_BITS-1:0]         root_ff, root_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ROOT_FIELD_BITS-1:0]   rsp_root_ff, rsp_root_in;

   cell_ctl_type                 ctl;
   logic [NCELLS-1:0]            rem_bits;
   logic [NCELLS-1:0]            rem_sh;
   logic [NCELLS-1:0]            trial;
   logic [NCELLS:0]              borrow;
   logic                         fit;
   logic [ROOT_BITS:0]           root_ext;
   logic [ROOT_BITS-1:0]         root_next;
   logic [ROOT_BITS+ROOT_FIELD_BITS-1:0] root_pad;
   logic                         last_step;

   // shifted remainder takes the next two radicand bits at the bottom
   assign rem_sh    = {rem_bits[NCELLS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign borrow[0] = 1'b0;
   assign fit       = ~borrow[NCELLS];

   genvar gi;
   generate
      for (gi = 0; gi < NCELLS; gi++) begin : g_row
         fsr_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .shift_in   (rem_sh[gi]),
            .trial_in   (trial[gi]),
            .borrow_in  (borrow[gi]),
            .borrow_out (borrow[gi+1]),
            .rem_out    (rem_bits[gi])
         );
      end
   endgenerate

   assign root_ext  = {root_ff, fit};
   assign root_next = root_ext[ROOT_BITS-1:0];
   assign root_pad  = {{ROOT_FIELD_BITS{1'b0}}, root_next};
   assign last_step = (count_ff == CNT_BITS'(ROOT_BITS - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rsp_valid_in = 1'b0;
      rsp_root_in  = rsp_root_ff;
      ctl          = '{clear: 1'b0, step: 1'b0, keep: fit};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.clear = 1'b1;
               rad_in    = RAD_BITS'(req_value);
               root_in   = '0;
               count_in  = '0;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            ctl.step = 1'b1;
            rad_in   = rad_ff << 2;
            root_in  = root_next;
            count_in = count_ff + 1'b1;
            if (last_step) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = root_pad[ROOT_FIELD_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      rsp_root_ff <= rsp_root_in;
   end

   assign busy      = (state_ff == ST_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = rsp_root_ff;

   `FSR_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy,
      "accepted item did not start the row")
   `FSR_ASSERT_DELAY(a_latency, clock, reset, start && !busy, LAT, rsp_valid,
      "result strobe missing at fixed latency")
   `FSR_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy && $past(busy),
      "result strobe outside the end of a run")
   `FSR_ASSERT_NOW(a_rem_bound, clock, reset, busy, rem_bits[NCELLS-1 -: 2] == 2'b00,
      "remainder exceeds twice the partial root")
   `FSR_ASSERT_NOW(a_count_bound, clock, reset, busy,
      count_ff <= CNT_BITS'(ROOT_BITS - 1), "step counter past last root bit")

endmodule

// ===== sim/tb_integer_floor_square_root_unit.sv =====
// Self-checking testbench for integer_floor_square_root_unit: directed and random radicands,
// with an in-bench floor square root predictor and a scoreboard class.
// Depends on fsr_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_integer_floor_square_root_unit;

   localparam int VALUE_BITS    = fsr_pkg::DEF_INPUT_BITS;
   localparam int ROOT_BITS     = fsr_pkg::ROOT_FIELD_BITS;
   localparam int RANDOM_ITEMS  = 1750;
   localparam int MAX_GAP       = 4;
   localparam int DRAIN_LIMIT   = 200;
   localparam int SETTLE_CYCLES = 20;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [ROOT_BITS-1:0]  root_type;

   class root_scoreboard;
      root_type pending_roots[$];
      int       mismatches;
      int       values_taken;
      int       roots_checked;
      int       perfect_squares;
      int       upper_half_values;

      function new();
         mismatches        = 0;
         values_taken      = 0;
         roots_checked     = 0;
         perfect_squares   = 0;
         upper_half_values = 0;
      endfunction

      // bit-serial floor root; square formed at 64 bits so nothing wraps
      function root_type floor_root(value_type v);
         root_type   r;
         root_type   cand;
         logic [63:0] sq;
         r = '0;
         for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            cand = r | (root_type'(1) << b);
            sq   = 64'(cand) * 64'(cand);
            if (sq <= 64'(v))
               r = cand;
         end
         return r;
      endfunction

      function void note_value(value_type v);
         root_type r;
         r = floor_root(v);
         pending_roots.push_back(r);
         values_taken++;
         if (64'(r) * 64'(r) == 64'(v))
            perfect_squares++;
         if (v[VALUE_BITS-1])
            upper_half_values++;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         mismatches++;
      endtask

      task check_root(root_type got);
         root_type want;
         if (pending_roots.size() == 0) begin
            report_mismatch($sformatf("unexpected root %0d", got));
         end else begin
            want = pending_roots.pop_front();
            roots_checked++;
            if (got !== want)
               report_mismatch($sformatf("root got %0d want %0d", got, want));
         end
      endtask

      function int pending_count();
         return pending_roots.size();
      endfunction
   endclass

   logic      clock;
   logic      reset;
   logic      start;
   value_type req_value;
   logic      busy;
   logic      rsp_valid;
   root_type  rsp_root;

   root_scoreboard sb;
   bit             idling_on;

   integer_floor_square_root_unit #(
      .INPUT_BITS(VALUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_value(req_value),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_root (rsp_root)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // pre-edge sampling of both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_value(req_value);
         if (rsp_valid)
            sb.check_root(rsp_root);
      end
   end

   // start stays high across back-to-back items unless an idle gap is drawn; returns when busy is low
   task automatic drive_value(input value_type v);
      int gap;
      gap = idling_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_all_roots();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   function automatic value_type random_value();
      int        pick;
      root_type  r;
      value_type sq;
      pick = $urandom_range(0, 99);
      r    = root_type'($urandom);
      sq   = VALUE_BITS'(32'(r) * 32'(r));
      if (pick < 40)
         return $urandom;
      else if (pick < 55)
         return sq;                        // perfect square
      else if (pick < 65)
         return sq - 1;                    // just below a square
      else if (pick < 72)
         return sq + 1;
      else if (pick < 87)
         return value_type'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
      else if (pick < 95)
         return $urandom_range(0, 300);
      else
         return ~value_type'($urandom_range(0, 300));
   endfunction

   initial begin
      value_type directed_values[$];
      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      idling_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd15, 32'd16, 32'd17,
                          32'd24, 32'd25, 32'd65535, 32'd65536, 32'hFFFF_FFFF,
                          32'hFFFE_0001, 32'hFFFE_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h4000_0000, 32'h3FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hFFFF_0000, 32'h0000_FFFF};
      foreach (directed_values[i])
         drive_value(directed_values[i]);
      wait_all_roots();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate idling and full-rate stretches
         if (n % 250 == 0)
            idling_on = ((n / 250) % 2) == 0;
         if (n == RANDOM_ITEMS / 2)
            wait_all_roots();
         drive_value(random_value());
      end
      start <= 1'b0;

      for (int c = 0; c < DRAIN_LIMIT && sb.pending_count() != 0; c++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending_count() != 0)
         sb.report_mismatch($sformatf("%0d roots never arrived", sb.pending_count()));

      $display("Summary: %0d radicands rooted, %0d roots checked, %0d perfect squares,",
               sb.values_taken, sb.roots_checked, sb.perfect_squares);
      $display("         %0d radicands with the top bit set, %0d mismatches",
               sb.upper_half_values, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Timeout after %0t", $time);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== integer_floor_square_root_unit.f =====
+incdir+rtl/core
rtl/core/fsr_pkg.sv
rtl/core/fsr_cell.sv
rtl/core/integer_floor_square_root_unit.sv
sim/tb_integer_floor_square_root_unit.sv
